[src/mcrp_pkg.sv]
package mcrp_pkg;

  // Frame layout: bytes 0 to 8 are covered by the CRC, byte 9 carries it.
  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned IDX_W     = 4;
  localparam logic [IDX_W-1:0] CHECK_POS  = 4'd9;
  localparam logic [IDX_W-1:0] IDLE_INDEX = 4'd10;

  // CRC-8/MAXIM, reflected form of polynomial 0x31.
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [7:0] CRC_INIT      = 8'h00;

  // Configuration register indexes.
  localparam logic CFG_FEEDBACK_ID = 1'b0;
  localparam logic CFG_POSITION_ID = 1'b1;

  typedef enum logic [1:0] {
    ST_CRC_BAD  = 2'd0,
    ST_FEEDBACK = 2'd1,
    ST_POSITION = 2'd2,
    ST_OTHER    = 2'd3
  } frame_status_t;

  // What the frame tracker hands to the report stage for one accepted word.
  typedef struct packed {
    logic             emit;    // the check byte has been accepted
    logic             crc_ok;  // running CRC equals the check byte
    logic [7:0]       kind;    // frame byte 1, the control ID
    logic [6:0][7:0]  body;    // body[k] is frame byte k+2
  } frame_info_t;

  // One byte step of the reflected CRC, one bit per iteration.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/mcrp_frame_track.sv]
module mcrp_frame_track
  import mcrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        in_data_byte,
  input  logic              in_frame_start,
  output logic              at_check,
  output frame_info_t       info
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       fb_r [8];

  logic [IDX_W-1:0] eff_idx;
  logic [7:0]       eff_crc;
  logic [IDX_W-1:0] wr_pos;
  logic             fb_we;

  // A start mark restarts the count and the CRC for this very word.
  assign eff_idx  = in_frame_start ? '0 : idx_r;
  assign eff_crc  = in_frame_start ? CRC_INIT : crc_r;
  assign at_check = (eff_idx == CHECK_POS);
  assign wr_pos   = eff_idx - 4'd1;
  assign fb_we    = in_accept && (eff_idx != '0) && (eff_idx < CHECK_POS);

  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    if (in_accept) begin
      if (eff_idx < CHECK_POS) begin
        crc_nxt = crc8_step(eff_crc, in_data_byte);
        idx_nxt = eff_idx + 4'd1;
      end else if (at_check) begin
        idx_nxt = IDLE_INDEX;
      end else begin
        idx_nxt = eff_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= CRC_INIT;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_r[wr_pos[2:0]] <= in_data_byte;
    end
  end

  always_comb begin
    info.emit   = in_accept && at_check;
    info.crc_ok = (eff_crc == in_data_byte);
    info.kind   = fb_r[0];
    for (int k = 0; k < 7; k++) begin
      info.body[k] = fb_r[k+1];
    end
  end

endmodule

[src/mcrp_report.sv]
module mcrp_report
  import mcrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  frame_info_t        info,
  input  logic [7:0]         feedback_id,
  input  logic [7:0]         position_id,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_frame_status,
  output logic signed [15:0] out_speed_raw,
  output logic signed [15:0] out_current_raw,
  output logic [7:0]         out_temperature,
  output logic [7:0]         out_error_code,
  output logic signed [31:0] out_turn_count,
  output logic [15:0]        out_position_raw
);

  logic          valid_r, valid_nxt;
  frame_status_t status_r, status_nxt;
  logic [15:0]   speed_r, speed_nxt;
  logic [15:0]   current_r, current_nxt;
  logic [15:0]   temp_err_r, temp_err_nxt;
  logic [31:0]   turns_r, turns_nxt;
  logic [15:0]   position_r, position_nxt;

  // The held fields only move when a new word is loaded into the result slot,
  // so they double as the result register.
  always_comb begin
    valid_nxt    = valid_r && !out_ready;
    status_nxt   = status_r;
    speed_nxt    = speed_r;
    current_nxt  = current_r;
    temp_err_nxt = temp_err_r;
    turns_nxt    = turns_r;
    position_nxt = position_r;
    if (info.emit) begin
      valid_nxt = 1'b1;
      if (!info.crc_ok) begin
        status_nxt = ST_CRC_BAD;
      end else if (info.kind == feedback_id) begin
        status_nxt   = ST_FEEDBACK;
        speed_nxt    = {info.body[0], info.body[1]};
        current_nxt  = {info.body[2], info.body[3]};
        temp_err_nxt = {info.body[5], info.body[6]};
      end else if (info.kind == position_id) begin
        status_nxt   = ST_POSITION;
        turns_nxt    = {info.body[0], info.body[1], info.body[2], info.body[3]};
        position_nxt = {info.body[4], info.body[5]};
      end else begin
        status_nxt = ST_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      status_r   <= ST_CRC_BAD;
      speed_r    <= '0;
      current_r  <= '0;
      temp_err_r <= '0;
      turns_r    <= '0;
      position_r <= '0;
    end else begin
      valid_r    <= valid_nxt;
      status_r   <= status_nxt;
      speed_r    <= speed_nxt;
      current_r  <= current_nxt;
      temp_err_r <= temp_err_nxt;
      turns_r    <= turns_nxt;
      position_r <= position_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_frame_status = status_r;
  assign out_speed_raw    = speed_r;
  assign out_current_raw  = current_r;
  assign out_temperature  = temp_err_r[15:8];
  assign out_error_code   = temp_err_r[7:0];
  assign out_turn_count   = turns_r;
  assign out_position_raw = position_r;

endmodule

[src/crc8_checked_motor_reply_parser_unit.sv]
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data_byte, in_frame_start
// out_      output     out_valid / out_ready  out_frame_status and held report fields
// cfg_      input      cfg_wr_en              cfg_index, cfg_wdata
//
// One word is taken per cycle while in_ready is high; the result of a frame appears
// in the cycle after its check byte is accepted, set by the single result register.
// Reset (rst_n low at a clock edge) clears the byte count, CRC, holds and IDs.
// A waiting result stalls only the next check byte; all other words flow on.
module crc8_checked_motor_reply_parser_unit
  import mcrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic signed [15:0] out_speed_raw,
  output logic signed [15:0] out_current_raw,
  output logic [7:0]         out_temperature,
  output logic [7:0]         out_error_code,
  output logic signed [31:0] out_turn_count,
  output logic [15:0]        out_position_raw,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0]  feedback_id_r, feedback_id_nxt;
  logic [7:0]  position_id_r, position_id_nxt;
  logic        in_accept;
  logic        at_check;
  frame_info_t info;

  // The configuration registers hold the two control IDs that sort a frame.
  always_comb begin
    feedback_id_nxt = feedback_id_r;
    position_id_nxt = position_id_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FEEDBACK_ID: feedback_id_nxt = cfg_wdata;
        CFG_POSITION_ID: position_id_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feedback_id_r <= '0;
      position_id_r <= '0;
    end else begin
      feedback_id_r <= feedback_id_nxt;
      position_id_r <= position_id_nxt;
    end
  end

  // Only a check byte produces a result, so only a check byte has to wait for
  // the result slot to be free or being emptied in the same cycle.
  assign in_ready  = !out_valid || out_ready || !at_check;
  assign in_accept = in_valid && in_ready;

  mcrp_frame_track u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .at_check       (at_check),
    .info           (info)
  );

  mcrp_report u_report (
    .clk              (clk),
    .rst_n            (rst_n),
    .info             (info),
    .feedback_id      (feedback_id_r),
    .position_id      (position_id_r),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_frame_status (out_frame_status),
    .out_speed_raw    (out_speed_raw),
    .out_current_raw  (out_current_raw),
    .out_temperature  (out_temperature),
    .out_error_code   (out_error_code),
    .out_turn_count   (out_turn_count),
    .out_position_raw (out_position_raw)
  );

  // A result is only ever loaded into a free or draining slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    info.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an unread word");

  // Every loaded result is offered on the next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    info.emit |=> out_valid)
    else $error("loaded result not offered");

  // The speed and turn-count holds move only with a result.
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !info.emit |=> ($stable(out_speed_raw) && $stable(out_turn_count)))
    else $error("held field changed without a frame");

  // A good frame of any kind other than feedback leaves the speed hold alone.
  a_position_keeps_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (info.emit && info.crc_ok && (info.kind != feedback_id_r)) |=> $stable(out_speed_raw))
    else $error("speed changed on a non-feedback frame");

endmodule

[tb/crc8_checked_motor_reply_parser_unit_tb.sv]
`timescale 1ns / 100ps

module crc8_checked_motor_reply_parser_unit_tb;
  import mcrp_pkg::*;

  // Cycles without any accepted word before the run is abandoned. The longest
  // deliberate silence is the receiver hold-off, which is far shorter.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Idle cycles allowed after the last result before a register write or the
  // final verdict.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned FRAMES_PER_SETTING = 6;

  // One expected result word.
  typedef struct {
    frame_status_t status;
    logic [15:0]   speed;
    logic [15:0]   current;
    logic [7:0]    temperature;
    logic [7:0]    error_code;
    logic [31:0]   turns;
    logic [15:0]   position;
  } reply_report_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_frame_start;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_frame_status;
  logic signed [15:0] out_speed_raw;
  logic signed [15:0] out_current_raw;
  logic [7:0]         out_temperature;
  logic [7:0]         out_error_code;
  logic signed [31:0] out_turn_count;
  logic [15:0]        out_position_raw;
  logic               cfg_wr_en;
  logic               cfg_index;
  logic [7:0]         cfg_wdata;

  crc8_checked_motor_reply_parser_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_speed_raw    (out_speed_raw),
    .out_current_raw  (out_current_raw),
    .out_temperature  (out_temperature),
    .out_error_code   (out_error_code),
    .out_turn_count   (out_turn_count),
    .out_position_raw (out_position_raw),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Results still owed by the parser, oldest first.
  reply_report_t pending_reports[$];

  // The testbench's own copy of the parser state and its two ID registers.
  logic [7:0]  feedback_id_copy;
  logic [7:0]  position_id_copy;
  logic [7:0]  crc_run;
  logic [3:0]  next_pos;
  logic [7:0]  kept_bytes [8];   // frame bytes 1 to 8 of the frame in progress
  logic [15:0] held_speed;
  logic [15:0] held_current;
  logic [7:0]  held_temperature;
  logic [7:0]  held_error;
  logic [31:0] held_turns;
  logic [15:0] held_position;

  int unsigned fault_count;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_off_request;
  int unsigned hold_left;

  always #1 clk = ~clk;

  // CRC-8/MAXIM worked bit by bit from the least significant data bit: the
  // feedback bit is the low CRC bit xor the incoming data bit.
  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[7:1]} ^ (fb ? CRC_POLY_REFL : 8'h00);
    end
    return r;
  endfunction

  // Byte values weighted towards the sign and range boundaries.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Advances the copy of the parser by one accepted word and, when the word
  // is a check byte, queues the result word that it must produce.
  task automatic track_reply_byte(input logic [7:0] b, input logic mark);
    reply_report_t r;
    if (mark) begin
      next_pos = '0;
      crc_run  = CRC_INIT;
    end
    // Past the check byte and no new start mark: the word is dropped.
    if (next_pos >= IDLE_INDEX) return;
    if (next_pos < CHECK_POS) begin
      crc_run = crc_next(crc_run, b);
      if (next_pos != 0) kept_bytes[next_pos - 1] = b;
      next_pos = next_pos + 4'd1;
      return;
    end
    next_pos = IDLE_INDEX;
    // The feedback ID is tested first, so equal IDs make a feedback reply.
    if (crc_run != b) begin
      r.status = ST_CRC_BAD;
    end else if (kept_bytes[0] == feedback_id_copy) begin
      r.status         = ST_FEEDBACK;
      held_speed       = {kept_bytes[1], kept_bytes[2]};
      held_current     = {kept_bytes[3], kept_bytes[4]};
      held_temperature = kept_bytes[6];
      held_error       = kept_bytes[7];
    end else if (kept_bytes[0] == position_id_copy) begin
      r.status      = ST_POSITION;
      held_turns    = {kept_bytes[1], kept_bytes[2], kept_bytes[3], kept_bytes[4]};
      held_position = {kept_bytes[5], kept_bytes[6]};
    end else begin
      r.status = ST_OTHER;
    end
    r.speed       = held_speed;
    r.current     = held_current;
    r.temperature = held_temperature;
    r.error_code  = held_error;
    r.turns       = held_turns;
    r.position    = held_position;
    pending_reports.push_back(r);
  endtask

  task automatic log_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("mismatch %0d at %0t: %s", fault_count, $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) log_fault($sformatf("%s expected %h got %h", name, want, got));
  endtask

  // Offers one word at a falling edge, after a random gap, and holds it until
  // the parser takes it at a rising edge. Returns just after that edge.
  task automatic send_word(input logic [7:0] value, input logic mark);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= value;
    in_frame_start <= mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_reply_byte(value, mark);
  endtask

  // Builds a reply frame with the given control ID and sends its first
  // 'cut' words. A negative fill gives random content, otherwise every
  // byte but the ID and the check byte takes the fill value.
  task automatic send_frame(input logic [7:0] kind, input bit good_crc, input int cut,
                            input bit mark, input int fill);
    logic [7:0] frame [FRAME_LEN];
    logic [7:0] acc;
    acc = CRC_INIT;
    for (int i = 0; i < CHECK_POS; i++) begin
      if (i == 1) frame[i] = kind;
      else if (fill < 0) frame[i] = pick_byte();
      else frame[i] = fill[7:0];
      acc = crc_next(acc, frame[i]);
    end
    frame[CHECK_POS] = good_crc ? acc : acc ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < cut; i++) send_word(frame[i], mark && i == 0);
  endtask

  // Drops the input valid, waits for every owed result and lets the parser
  // settle, so that it is idle afterwards.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_FEEDBACK_ID) feedback_id_copy = value;
    else position_id_copy = value;
  endtask

  task automatic set_ids(input logic [7:0] feedback_id, input logic [7:0] position_id);
    quiesce();
    write_reg(CFG_FEEDBACK_ID, feedback_id);
    write_reg(CFG_POSITION_ID, position_id);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Mostly well-formed frames of both known kinds, with bad checks, unknown
  // kinds, truncated frames and stray words after a frame mixed in.
  task automatic run_frames(input int unsigned count);
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_frame(feedback_id_copy, 1'b1, FRAME_LEN, 1'b1, -1);
      end else if (pick < 65) begin
        send_frame(position_id_copy, 1'b1, FRAME_LEN, 1'b1, -1);
      end else if (pick < 75) begin
        send_frame(pick_byte(), 1'b1, FRAME_LEN, 1'b1, -1);
      end else if (pick < 85) begin
        send_frame(pick_byte(), 1'b0, FRAME_LEN, 1'b1, -1);
      end else if (pick < 93) begin
        send_frame(pick_byte(), 1'b1, $urandom_range(CHECK_POS, 1), 1'b1, -1);
      end else begin
        send_frame($urandom_range(1) ? feedback_id_copy : position_id_copy, 1'b1,
                   FRAME_LEN, 1'b1, -1);
        repeat ($urandom_range(4, 1)) send_word(pick_byte(), 1'b0);
      end
    end
  endtask

  // Straight after reset both IDs are zero and the byte count is at zero, so
  // an unmarked frame is taken from its first word and, the IDs being equal,
  // counts as feedback. Words after its check byte are ignored. A start mark
  // part way through a frame drops it; the frame that follows carries all
  // ones into the position holds.
  task automatic test_directed();
    send_frame(8'h00, 1'b1, FRAME_LEN, 1'b0, 'h80);
    send_word(8'h5A, 1'b0);
    send_word(8'hA5, 1'b0);
    set_ids(8'hFF, 8'h00);
    send_frame(8'h3C, 1'b1, 3, 1'b1, -1);
    send_frame(8'h00, 1'b1, FRAME_LEN, 1'b1, 'hFF);
  endtask

  task automatic test_id_extremes();
    set_ids(8'h00, 8'hFF);
    run_frames(FRAMES_PER_SETTING);
    set_ids(8'hFF, 8'h00);
    run_frames(FRAMES_PER_SETTING);
  endtask

  // With both IDs the same, a matching frame must always update the feedback
  // holds and never the position holds.
  task automatic test_equal_ids();
    logic [7:0] shared_id;
    shared_id = pick_byte();
    set_ids(shared_id, shared_id);
    run_frames(FRAMES_PER_SETTING);
  endtask

  task automatic test_random_ids();
    set_ids(pick_byte(), pick_byte());
    run_frames(FRAMES_PER_SETTING);
    set_ids(8'h7F, 8'h80);
    run_frames(FRAMES_PER_SETTING);
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so
  // the unread result blocks the next check byte and the input stalls.
  task automatic test_backpressure();
    quiesce();
    @(posedge clk);
    hold_off_request = HOLD_OFF_CYCLES;
    run_frames(5);
  endtask

  // Receiver: random stalls, with a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_request != 0) begin
      hold_left        = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    reply_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        log_fault("result word with no frame awaiting it");
      end else begin
        want = pending_reports.pop_front();
        check_field("frame_status", {30'h0, want.status}, {30'h0, out_frame_status});
        check_field("speed_raw", {16'h0, want.speed}, {16'h0, out_speed_raw});
        check_field("current_raw", {16'h0, want.current}, {16'h0, out_current_raw});
        check_field("temperature", {24'h0, want.temperature}, {24'h0, out_temperature});
        check_field("error_code", {24'h0, want.error_code}, {24'h0, out_error_code});
        check_field("turn_count", want.turns, out_turn_count);
        check_field("position_raw", {16'h0, want.position}, {16'h0, out_position_raw});
      end
    end
  end

  // Watchdog: a long run of cycles with no word moving on either channel
  // means the parser has hung or lost a result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = 8'h00;
    in_frame_start   = 1'b0;
    out_ready        = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = CFG_FEEDBACK_ID;
    cfg_wdata        = 8'h00;
    feedback_id_copy = 8'h00;
    position_id_copy = 8'h00;
    crc_run          = CRC_INIT;
    next_pos         = '0;
    held_speed       = '0;
    held_current     = '0;
    held_temperature = '0;
    held_error       = '0;
    held_turns       = '0;
    held_position    = '0;
    for (int i = 0; i < 8; i++) kept_bytes[i] = '0;
    fault_count      = 0;
    quiet_cycles     = 0;
    hold_off_request = 0;
    hold_left        = 0;
    set_idling(29, 52);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender idles less often than the receiver first.
    test_directed();
    test_id_extremes();
    test_backpressure();

    // Then the other way round.
    set_idling(52, 29);
    test_equal_ids();
    test_random_ids();

    // Finally full throughput on both sides.
    set_idling(0, 0);
    test_random_ids();
    test_id_extremes();

    quiesce();
    if (fault_count == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
